FILE: hw/rtl/radix2_complex_fft_assert.svh
// ----------------------------------------------------------------------------
// Radix-2 FFT assertion macros
// Shared concurrent check macros; clocked on clk, disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef RADIX2_COMPLEX_FFT_ASSERT_SVH
`define RADIX2_COMPLEX_FFT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define R2F_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("r2fft check failed");
// next-cycle implication
`define R2F_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("r2fft check failed");
`else
`define R2F_ASSERT_IMP(lbl, a, b)
`define R2F_ASSERT_NXT(lbl, a, b)
`endif
`endif

FILE: hw/rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT package
// Sizes, request types, command struct, state codes and the twiddle table.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int LOG2_MAX_LENGTH = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_LENGTH      = 1 << LOG2_MAX_LENGTH;
  localparam int HALF_MAX        = MAX_LENGTH >> 1;
  localparam int ADDR_BITS       = LOG2_MAX_LENGTH;
  localparam int CNT_BITS        = LOG2_MAX_LENGTH + 1;
  localparam int TW_IDX_BITS     = LOG2_MAX_LENGTH - 1;
  localparam int TW_BITS         = 17;
  localparam int DATA_BITS       = 32;
  localparam int LG_BITS         = 4;
  localparam int CFG_BITS        = 4;
  localparam int CFG_IDX_BITS    = 2;
  localparam int PROD_BITS       = DATA_BITS + TW_BITS + 1;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_DC = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOG2_LEN  = 2'd2;

  localparam logic [LG_BITS-1:0] LG_MIN   = LG_BITS'(1);
  localparam logic [LG_BITS-1:0] LG_MAX   = LG_BITS'(LOG2_MAX_LENGTH);
  localparam logic [LG_BITS-1:0] LG_RESET = LG_BITS'(10);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] result_real;
    logic signed [DATA_BITS-1:0] result_imag;
    logic [ADDR_BITS-1:0]        bin_index;
    logic                        last_bin;
    logic                        empty_res;
  } out_item_t;

  typedef enum logic [1:0] {OP_BFLY, OP_SWAP, OP_SCALE} op_t;
  typedef enum logic [1:0] {MODE_NORMAL, MODE_FIRST, MODE_LAST} mode_t;
  typedef enum logic [1:0] {PH_REV, PH_BFLY, PH_SCALE} phase_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_PULL, ST_SEL, ST_RD, ST_MUL, ST_TW, ST_WA, ST_WB
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic                   ld_en;
    logic                   rd_en;
    logic                   mul_en;
    logic                   t_en;
    logic                   wr_a;
    logic                   wr_b;
    logic                   out_load;
    logic                   out_empty;
    logic                   out_last;
    op_t                    op;
    mode_t                  mode;
    logic                   inverse;
    logic [LG_BITS-1:0]     lg;
    logic [ADDR_BITS-1:0]   addr_a;
    logic [ADDR_BITS-1:0]   addr_b;
    logic [TW_IDX_BITS-1:0] tw_idx;
  } cmd_t;

  typedef logic signed [TW_BITS-1:0] tw_val_t;
  typedef tw_val_t tw_rom_t [HALF_MAX];

  // Twiddle table in Q2.15, built from Q30 half-angle rotations.
  function automatic tw_rom_t build_tw(input logic want_sin);
    longint          bc [LOG2_MAX_LENGTH];
    longint          bs [LOG2_MAX_LENGTH];
    longint unsigned x, r, bt, ch, num, rem, q;
    longint          c, s, nc, ns;
    int              top;
    tw_rom_t         rom;
    top = LOG2_MAX_LENGTH - 2;
    if (top >= 0) begin
      bc[top] = 0;
      bs[top] = longint'(1) << 30;
      for (int b = top; b > 0; b--) begin
        // integer square root
        x  = longint'((longint'(1) << 30) + bc[b]) << 29;
        r  = 0;
        bt = longint'(1) << 62;
        for (int k = 0; k < 32; k++) begin
          if (x >= r + bt) begin
            x = x - (r + bt);
            r = (r >> 1) + bt;
          end else begin
            r = r >> 1;
          end
          bt = bt >> 2;
        end
        ch = r;
        // rounded quotient by long division
        num = (longint'(bs[b]) << 29) + (ch >> 1);
        rem = 0;
        q   = 0;
        for (int k = 63; k >= 0; k--) begin
          rem = (rem << 1) | ((num >> k) & 1);
          if (rem >= ch) begin
            rem = rem - ch;
            q   = q | (longint'(1) << k);
          end
        end
        bc[b-1] = longint'(ch);
        bs[b-1] = longint'(q);
      end
    end
    for (int k = 0; k < HALF_MAX; k++) begin
      c = longint'(1) << 30;
      s = 0;
      for (int b = 0; b <= top; b++) begin
        if (((k >> b) & 1) != 0) begin
          nc = (c * bc[b] - s * bs[b] + (longint'(1) << 29)) >>> 30;
          ns = (c * bs[b] + s * bc[b] + (longint'(1) << 29)) >>> 30;
          c  = nc;
          s  = ns;
        end
      end
      if (want_sin) rom[k] = tw_val_t'((s + 16384) >>> 15);
      else          rom[k] = tw_val_t'((c + 16384) >>> 15);
    end
    return rom;
  endfunction

endpackage

FILE: hw/rtl/r2fft_dp.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT datapath
// Frame store, twiddle table, shared butterfly unit, scaler, result register.
// ----------------------------------------------------------------------------
module r2fft_dp (
  input  logic                 clk,
  input  r2fft_pkg::cmd_t      cmd,
  input  r2fft_pkg::in_item_t  in_data,
  output r2fft_pkg::out_item_t out_data
);
  import r2fft_pkg::*;

  localparam tw_rom_t TW_COS = build_tw(1'b0);
  localparam tw_rom_t TW_SIN = build_tw(1'b1);

  logic [2*DATA_BITS-1:0] mem [MAX_LENGTH];
  logic [2*DATA_BITS-1:0] xa_r, xb_r;
  tw_val_t                tw_cos_r, tw_sin_r;
  logic signed [PROD_BITS-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [DATA_BITS-1:0] t_re_r, t_im_r;
  out_item_t              out_r;

  logic signed [DATA_BITS-1:0] src_re, src_im, base_re, base_im;
  logic signed [TW_BITS:0]     w_re, w_im;
  logic signed [PROD_BITS:0]   sum_re, sum_im;
  logic signed [DATA_BITS-1:0] plus_re, plus_im, minus_re, minus_im;
  logic signed [DATA_BITS-1:0] sc_re, sc_im;
  logic signed [DATA_BITS:0]   bias;
  logic [2*DATA_BITS-1:0]      res_a, res_b, wr_data;
  logic [ADDR_BITS-1:0]        wr_addr;
  logic                        wr_en;

  // store read ports and twiddle fetch
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      xa_r     <= mem[cmd.addr_a];
      xb_r     <= mem[cmd.addr_b];
      tw_cos_r <= TW_COS[cmd.tw_idx];
      tw_sin_r <= TW_SIN[cmd.tw_idx];
    end
  end

  // operand select; first-stage form rotates a and keeps b
  always_comb begin
    if (cmd.mode == MODE_FIRST) begin
      src_re  = xa_r[2*DATA_BITS-1:DATA_BITS];
      src_im  = xa_r[DATA_BITS-1:0];
      base_re = xb_r[2*DATA_BITS-1:DATA_BITS];
      base_im = xb_r[DATA_BITS-1:0];
    end else begin
      src_re  = xb_r[2*DATA_BITS-1:DATA_BITS];
      src_im  = xb_r[DATA_BITS-1:0];
      base_re = xa_r[2*DATA_BITS-1:DATA_BITS];
      base_im = xa_r[DATA_BITS-1:0];
    end
    w_re = {tw_cos_r[TW_BITS-1], tw_cos_r};
    w_im = cmd.inverse ? {tw_sin_r[TW_BITS-1], tw_sin_r}
                       : -{tw_sin_r[TW_BITS-1], tw_sin_r};
  end

  // products
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rr_r <= PROD_BITS'(w_re * src_re);
      p_ii_r <= PROD_BITS'(w_im * src_im);
      p_ri_r <= PROD_BITS'(w_re * src_im);
      p_ir_r <= PROD_BITS'(w_im * src_re);
    end
  end

  // rounded rotation
  always_comb begin
    sum_re = (PROD_BITS+1)'(p_rr_r) - (PROD_BITS+1)'(p_ii_r) + (PROD_BITS+1)'(16384);
    sum_im = (PROD_BITS+1)'(p_ri_r) + (PROD_BITS+1)'(p_ir_r) + (PROD_BITS+1)'(16384);
  end

  always_ff @(posedge clk) begin
    if (cmd.t_en) begin
      t_re_r <= DATA_BITS'(sum_re >>> 15);
      t_im_r <= DATA_BITS'(sum_im >>> 15);
    end
  end

  // butterfly sums, swap and inverse scaling
  always_comb begin
    plus_re  = base_re + t_re_r;
    plus_im  = base_im + t_im_r;
    minus_re = base_re - t_re_r;
    minus_im = base_im - t_im_r;
    bias     = (DATA_BITS+1)'(1) <<< (cmd.lg - LG_BITS'(1));
    sc_re    = DATA_BITS'(((DATA_BITS+1)'(signed'(xa_r[2*DATA_BITS-1:DATA_BITS])) + bias)
                           >>> cmd.lg);
    sc_im    = DATA_BITS'(((DATA_BITS+1)'(signed'(xa_r[DATA_BITS-1:0])) + bias) >>> cmd.lg);
    case (cmd.op)
      OP_SWAP: begin
        res_a = xb_r;
        res_b = xa_r;
      end
      OP_SCALE: begin
        res_a = {sc_re, sc_im};
        res_b = xb_r;
      end
      default: begin
        if (cmd.mode == MODE_LAST) begin
          res_a = {minus_re, minus_im};
          res_b = {plus_re, plus_im};
        end else begin
          res_a = {plus_re, plus_im};
          res_b = {minus_re, minus_im};
        end
      end
    endcase
  end

  // single write port
  always_comb begin
    wr_en   = cmd.ld_en | cmd.wr_a | cmd.wr_b;
    wr_addr = cmd.wr_b ? cmd.addr_b : cmd.addr_a;
    if (cmd.ld_en)
      wr_data = {{(DATA_BITS-SAMPLE_BITS){in_data.sample_real[SAMPLE_BITS-1]}},
                 in_data.sample_real,
                 {(DATA_BITS-SAMPLE_BITS){in_data.sample_imag[SAMPLE_BITS-1]}},
                 in_data.sample_imag};
    else if (cmd.wr_b)
      wr_data = res_b;
    else
      wr_data = res_a;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        out_r <= '{result_real: '0, result_imag: '0, bin_index: '0,
                   last_bin: 1'b0, empty_res: 1'b1};
      end else begin
        out_r.result_real <= xa_r[2*DATA_BITS-1:DATA_BITS];
        out_r.result_imag <= xa_r[DATA_BITS-1:0];
        out_r.bin_index   <= cmd.addr_a;
        out_r.last_bin    <= cmd.out_last;
        out_r.empty_res   <= 1'b0;
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// Radix-2 FFT controller
// Configuration, load and read pointers, transform sequencer, handshakes.
// ----------------------------------------------------------------------------
module r2fft_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                cfg_wr_en,
  input  logic [r2fft_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [r2fft_pkg::CFG_BITS-1:0]      cfg_wdata,
  output r2fft_pkg::cmd_t                     cmd
);
  import r2fft_pkg::*;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  inverse_r, center_r;
  logic [LG_BITS-1:0]    lg_r;
  logic [CNT_BITS-1:0]   load_r, load_nxt, rp_r, rp_nxt, i_r, i_nxt;
  logic [CNT_BITS-2:0]   m_r, m_nxt;
  logic [LG_BITS-1:0]    s_r, s_nxt;
  logic                  ready_r, ready_nxt, out_valid_r;

  logic [LG_BITS-1:0]    lg_act;
  logic [CNT_BITS-1:0]   n_w, half_w, istep, i_step_sum, m_inc, ld_inc, p_inc;
  logic [ADDR_BITS-1:0]  rv_full, rev, tw_sh;
  logic                  rev_gt, i_end, s_done, in_acc, pull_last;

  // length in use
  always_comb begin
    if (lg_r < LG_MIN)      lg_act = LG_MIN;
    else if (lg_r > LG_MAX) lg_act = LG_MAX;
    else                    lg_act = lg_r;
  end

  // loop arithmetic
  always_comb begin
    n_w        = CNT_BITS'(1) << lg_act;
    half_w     = CNT_BITS'(1) << (s_r - LG_BITS'(1));
    istep      = half_w << 1;
    i_step_sum = i_r + istep;
    m_inc      = {1'b0, m_r} + CNT_BITS'(1);
    ld_inc     = load_r + CNT_BITS'(1);
    p_inc      = {1'b0, rp_r[ADDR_BITS-1:0]} + CNT_BITS'(1);
    pull_last  = p_inc >= n_w;
    for (int b = 0; b < ADDR_BITS; b++) rv_full[b] = i_r[ADDR_BITS-1-b];
    rev        = rv_full >> (LG_BITS'(ADDR_BITS) - lg_act);
    rev_gt     = {1'b0, rev} > i_r;
    i_end      = i_r == n_w;
    s_done     = s_r > lg_act;
    tw_sh      = m_r << (LG_BITS'(ADDR_BITS) - s_r);
    in_acc     = in_valid & ~in_stall;
  end

  assign in_stall  = (state_r != ST_IDLE) | (out_valid_r & (in_func == FUNC_PULL));
  assign out_valid = out_valid_r;

  // counter updates
  always_comb begin
    load_nxt  = load_r;
    rp_nxt    = rp_r;
    i_nxt     = i_r;
    m_nxt     = m_r;
    s_nxt     = s_r;
    phase_nxt = phase_r;
    ready_nxt = ready_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_PUSH && !ready_r) begin
          if (ld_inc >= n_w) begin
            load_nxt  = '0;
            phase_nxt = PH_REV;
            i_nxt     = '0;
          end else begin
            load_nxt  = ld_inc;
          end
        end
      end
      ST_PULL: begin
        if (pull_last) begin
          ready_nxt = 1'b0;
          rp_nxt    = '0;
        end else begin
          rp_nxt    = p_inc;
        end
      end
      ST_SEL: begin
        case (phase_r)
          PH_REV: begin
            if (i_end) begin
              phase_nxt = PH_BFLY;
              s_nxt     = LG_BITS'(1);
              m_nxt     = '0;
              i_nxt     = '0;
            end else if (!rev_gt) begin
              i_nxt     = i_r + CNT_BITS'(1);
            end
          end
          PH_BFLY: begin
            if (s_done) begin
              if (inverse_r) begin
                phase_nxt = PH_SCALE;
                i_nxt     = '0;
              end else begin
                ready_nxt = 1'b1;
                rp_nxt    = '0;
              end
            end
          end
          default: begin
            if (i_end) begin
              ready_nxt = 1'b1;
              rp_nxt    = '0;
            end
          end
        endcase
      end
      ST_WA: begin
        if (phase_r == PH_SCALE) i_nxt = i_r + CNT_BITS'(1);
      end
      ST_WB: begin
        if (phase_r == PH_BFLY) begin
          if (i_step_sum < n_w) begin
            i_nxt = i_step_sum;
          end else if (m_inc < half_w) begin
            m_nxt = m_inc[CNT_BITS-2:0];
            i_nxt = m_inc;
          end else begin
            s_nxt = s_r + LG_BITS'(1);
            m_nxt = '0;
            i_nxt = '0;
          end
        end else begin
          i_nxt = i_r + CNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_PULL && ready_r)
          state_nxt = ST_PULL;
        else if (in_acc && in_func == FUNC_PUSH && !ready_r && ld_inc >= n_w)
          state_nxt = ST_SEL;
      end
      ST_PULL: state_nxt = ST_IDLE;
      ST_SEL: begin
        case (phase_r)
          PH_REV:  state_nxt = (!i_end && rev_gt) ? ST_RD : ST_SEL;
          PH_BFLY: state_nxt = !s_done ? ST_RD : (inverse_r ? ST_SEL : ST_IDLE);
          default: state_nxt = i_end ? ST_IDLE : ST_RD;
        endcase
      end
      ST_RD:  state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_TW;
      ST_TW:  state_nxt = ST_WA;
      ST_WA:  state_nxt = (phase_r == PH_SCALE) ? ST_SEL : ST_WB;
      ST_WB:  state_nxt = ST_SEL;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd           = '0;
    cmd.inverse   = inverse_r;
    cmd.lg        = lg_act;
    cmd.tw_idx    = tw_sh[TW_IDX_BITS-1:0];
    cmd.out_last  = pull_last;
    cmd.mode      = MODE_NORMAL;
    if (phase_r == PH_BFLY && center_r) begin
      if (s_r == lg_act)            cmd.mode = MODE_LAST;
      else if (s_r == LG_BITS'(1))  cmd.mode = MODE_FIRST;
    end
    case (phase_r)
      PH_REV:   cmd.op = OP_SWAP;
      PH_SCALE: cmd.op = OP_SCALE;
      default:  cmd.op = OP_BFLY;
    endcase
    cmd.addr_a = i_r[ADDR_BITS-1:0];
    case (phase_r)
      PH_REV:  cmd.addr_b = rev;
      default: cmd.addr_b = ADDR_BITS'(i_r + half_w);
    endcase
    case (state_r)
      ST_IDLE: begin
        if (in_func == FUNC_PUSH) begin
          cmd.addr_a = load_r[ADDR_BITS-1:0];
          cmd.ld_en  = in_acc & ~ready_r;
        end else begin
          cmd.addr_a    = rp_r[ADDR_BITS-1:0];
          cmd.rd_en     = in_acc & ready_r;
          cmd.out_load  = in_acc & ~ready_r;
          cmd.out_empty = 1'b1;
        end
      end
      ST_PULL: begin
        cmd.addr_a   = rp_r[ADDR_BITS-1:0];
        cmd.out_load = 1'b1;
      end
      ST_RD:  cmd.rd_en  = 1'b1;
      ST_MUL: cmd.mul_en = 1'b1;
      ST_TW:  cmd.t_en   = 1'b1;
      ST_WA:  cmd.wr_a   = 1'b1;
      ST_WB:  cmd.wr_b   = 1'b1;
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_REV;
      inverse_r   <= 1'b0;
      center_r    <= 1'b0;
      lg_r        <= LG_RESET;
      load_r      <= '0;
      rp_r        <= '0;
      i_r         <= '0;
      m_r         <= '0;
      s_r         <= LG_BITS'(1);
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      load_r      <= load_nxt;
      rp_r        <= rp_nxt;
      i_r         <= i_nxt;
      m_r         <= m_nxt;
      s_r         <= s_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= cmd.out_load | (out_valid_r & out_stall);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_INVERSE:   inverse_r <= cfg_wdata[0];
          REG_CENTER_DC: center_r  <= cfg_wdata[0];
          REG_LOG2_LEN:  lg_r      <= cfg_wdata[LG_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/radix2_complex_fft.sv
// Push requests are taken one per cycle while idle; the push that completes a
// frame starts the transform: a bit-reversed reorder scan with swaps, the
// butterflies of every stage, and for an inverse a scaling pass. An empty pull
// result is registered from the request; a full one is read from the frame
// store and then registered. A pull waits while a result is held. Synchronous
// active-low reset clears control state; the frame store is not cleared.
// ----------------------------------------------------------------------------
// Radix-2 complex FFT
// In-place decimation-in-time transform with a single shared butterfly unit.
// ----------------------------------------------------------------------------
module radix2_complex_fft (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  r2fft_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output r2fft_pkg::out_item_t                out_data,
  input  logic                                cfg_wr_en,
  input  logic [r2fft_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [r2fft_pkg::CFG_BITS-1:0]      cfg_wdata
);
  import r2fft_pkg::*;

  `include "radix2_complex_fft_assert.svh"

  cmd_t cmd;

  r2fft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd)
  );

  r2fft_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // checks
  `R2F_ASSERT_IMP(a_one_write, 1'b1, $onehot0({cmd.ld_en, cmd.wr_a, cmd.wr_b}))
  `R2F_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid)
  `R2F_ASSERT_IMP(a_empty_zero, out_valid && out_data.empty_res, out_data.bin_index == '0)
  `R2F_ASSERT_IMP(a_no_load_busy, out_valid && out_stall, !cmd.out_load)

endmodule

FILE: sim/radix2_complex_fft_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix-2 FFT checker
// Watches the request, result and register ports and keeps its own model of
// the frame store. It predicts every pull result and compares it, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module radix2_complex_fft_checker
  import r2fft_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_item_t                in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  out_item_t               out_data,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata,
  output int                      pending,
  output int                      fail_count
);

  // twiddle table, Q2.15
  longint tw_cos [HALF_MAX];
  longint tw_sin [HALF_MAX];

  // mirrored registers and block state
  logic                        m_inverse;
  logic                        m_center;
  logic [LG_BITS-1:0]          m_lg;
  logic signed [DATA_BITS-1:0] bank_re [MAX_LENGTH];
  logic signed [DATA_BITS-1:0] bank_im [MAX_LENGTH];
  int unsigned                 fill_count;
  int unsigned                 bin_ptr;
  logic                        frame_done;
  out_item_t                   bins_due [$];

  assign pending = bins_due.size();

  // Half-angle recursion from pi/2, products rounded half up to Q30
  function automatic void make_twiddles();
    longint          bc [LOG2_MAX_LENGTH];
    longint          bs [LOG2_MAX_LENGTH];
    longint unsigned x, root, bit_w, ch;
    longint          c, s, nc, ns;
    int              top;
    top = LOG2_MAX_LENGTH - 2;
    bc[top] = 0;
    bs[top] = longint'(1) << 30;
    for (int b = top; b > 0; b--) begin
      x = longint'((longint'(1) << 30) + bc[b]) << 29;
      root = 0;
      bit_w = longint'(1) << 62;
      while (bit_w > x) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (x >= root + bit_w) begin
          x = x - (root + bit_w);
          root = (root >> 1) + bit_w;
        end else begin
          root = root >> 1;
        end
        bit_w = bit_w >> 2;
      end
      ch = root;
      bc[b-1] = longint'(ch);
      bs[b-1] = longint'(((longint'(bs[b]) << 29) + ch / 2) / ch);
    end
    for (int k = 0; k < HALF_MAX; k++) begin
      c = longint'(1) << 30;
      s = 0;
      for (int b = 0; b <= top; b++) begin
        if ((k >> b) & 1) begin
          nc = (c * bc[b] - s * bs[b] + (longint'(1) << 29)) >>> 30;
          ns = (c * bs[b] + s * bc[b] + (longint'(1) << 29)) >>> 30;
          c = nc;
          s = ns;
        end
      end
      tw_cos[k] = (c + 16384) >>> 15;
      tw_sin[k] = (s + 16384) >>> 15;
    end
  endfunction

  function automatic int unsigned span_log2();
    if (m_lg < LG_MIN) return LG_MIN;
    if (m_lg > LG_MAX) return LG_MAX;
    return m_lg;
  endfunction

  // In-place transform of the loaded frame
  function automatic void transform_frame();
    int unsigned lg, n, rev, half, tw_at, src, j;
    int          form;
    longint      wr, wi, xr, xi, tr, ti, ar, ai, br, bi, bias;
    logic signed [DATA_BITS-1:0] hold;
    lg = span_log2();
    n = 1 << lg;
    // bit-reversed reorder
    for (int unsigned i = 0; i < n; i++) begin
      rev = 0;
      for (int t = 0; t < lg; t++) rev = (rev << 1) | ((i >> t) & 1);
      if (rev > i) begin
        hold = bank_re[i]; bank_re[i] = bank_re[rev]; bank_re[rev] = hold;
        hold = bank_im[i]; bank_im[i] = bank_im[rev]; bank_im[rev] = hold;
      end
    end
    // butterfly stages; form 1 = centred first stage, 2 = centred last stage
    for (int unsigned st = 1; st <= lg; st++) begin
      half = 1 << (st - 1);
      form = 0;
      if (m_center && st == lg) form = 2;
      else if (m_center && st == 1) form = 1;
      for (int unsigned m = 0; m < half; m++) begin
        tw_at = m << (LOG2_MAX_LENGTH - st);
        wr = tw_cos[tw_at];
        wi = m_inverse ? tw_sin[tw_at] : -tw_sin[tw_at];
        for (int unsigned i = m; i < n; i += 2 * half) begin
          j = i + half;
          src = (form == 1) ? i : j;
          xr = bank_re[src];
          xi = bank_im[src];
          tr = (wr * xr - wi * xi + 16384) >>> 15;
          ti = (wr * xi + wi * xr + 16384) >>> 15;
          ar = bank_re[i]; ai = bank_im[i];
          br = bank_re[j]; bi = bank_im[j];
          case (form)
            0: begin
              bank_re[j] = DATA_BITS'(ar - tr); bank_im[j] = DATA_BITS'(ai - ti);
              bank_re[i] = DATA_BITS'(ar + tr); bank_im[i] = DATA_BITS'(ai + ti);
            end
            2: begin
              bank_re[j] = DATA_BITS'(ar + tr); bank_im[j] = DATA_BITS'(ai + ti);
              bank_re[i] = DATA_BITS'(ar - tr); bank_im[i] = DATA_BITS'(ai - ti);
            end
            default: begin
              bank_re[i] = DATA_BITS'(br + tr); bank_im[i] = DATA_BITS'(bi + ti);
              bank_re[j] = DATA_BITS'(br - tr); bank_im[j] = DATA_BITS'(bi - ti);
            end
          endcase
        end
      end
    end
    // inverse: divide by length, ties rounded up
    if (m_inverse) begin
      bias = longint'(1) << (lg - 1);
      for (int unsigned i = 0; i < n; i++) begin
        bank_re[i] = DATA_BITS'((longint'(bank_re[i]) + bias) >>> lg);
        bank_im[i] = DATA_BITS'((longint'(bank_im[i]) + bias) >>> lg);
      end
    end
  endfunction

  // Predict the effect of one accepted request
  function automatic void apply_request(in_item_t req);
    int unsigned n, p;
    out_item_t   bin;
    n = 1 << span_log2();
    bin = '0;
    if (req.func == FUNC_PUSH) begin
      if (frame_done) return;
      bank_re[fill_count % MAX_LENGTH] = DATA_BITS'(req.sample_real);
      bank_im[fill_count % MAX_LENGTH] = DATA_BITS'(req.sample_imag);
      fill_count++;
      if (fill_count >= n) begin
        transform_frame();
        frame_done = 1'b1;
        bin_ptr = 0;
        fill_count = 0;
      end
    end else if (!frame_done) begin
      bin.empty_res = 1'b1;
      bins_due.push_back(bin);
    end else begin
      p = bin_ptr % MAX_LENGTH;
      bin.result_real = bank_re[p];
      bin.result_imag = bank_im[p];
      bin.bin_index = ADDR_BITS'(p);
      bin.last_bin = (p + 1 >= n);
      bins_due.push_back(bin);
      if (bin.last_bin) begin
        frame_done = 1'b0;
        bin_ptr = 0;
      end else begin
        bin_ptr = p + 1;
      end
    end
  endfunction

  initial begin
    make_twiddles();
    for (int i = 0; i < MAX_LENGTH; i++) begin
      bank_re[i] = '0;
      bank_im[i] = '0;
    end
  end

  // Watch the ports at each rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      m_inverse = 1'b0;
      m_center = 1'b0;
      m_lg = LG_RESET;
      fill_count = 0;
      bin_ptr = 0;
      frame_done = 1'b0;
      bins_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_INVERSE:   m_inverse = cfg_wdata[0];
          REG_CENTER_DC: m_center = cfg_wdata[0];
          REG_LOG2_LEN:  m_lg = cfg_wdata[LG_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (bins_due.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = bins_due.pop_front();
          if (out_data.result_real !== want.result_real ||
              out_data.result_imag !== want.result_imag ||
              out_data.bin_index !== want.bin_index ||
              out_data.last_bin !== want.last_bin ||
              out_data.empty_res !== want.empty_res) begin
            $display("%0t: result mismatch, expected %p, actual %p",
                     $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) apply_request(in_data);
    end
  end

endmodule

FILE: sim/radix2_complex_fft_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix-2 FFT testbench
// Loads and reads back frames of many lengths, directions and DC placements,
// with random idle cycles on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module radix2_complex_fft_tb;
  import r2fft_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  out_item_t               out_data;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;
  int                      pending;
  int                      fail_count;
  int                      cycles = 0;
  int                      req_count;
  logic                    calm;

  radix2_complex_fft dut (.*);

  radix2_complex_fft_checker u_checker (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[radix2_complex_fft] ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);

  // one request, held until accepted
  task automatic send_req(input logic f, input logic signed [15:0] re,
                          input logic signed [15:0] im);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{func: f, sample_real: re, sample_imag: im};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    req_count++;
  endtask

  // pull with a random, ignored payload
  task automatic send_pull();
    send_req(FUNC_PULL, 16'($urandom()), 16'($urandom()));
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] val);
    in_valid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // all results in and the block left to settle
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_mode(input logic inv, input logic ctr, input int lg);
    drain();
    write_reg(REG_INVERSE, CFG_BITS'(inv));
    write_reg(REG_CENTER_DC, CFG_BITS'(ctr));
    write_reg(REG_LOG2_LEN, CFG_BITS'(lg));
  endtask

  // load a frame of 2^lg samples, then read it back
  task automatic run_frame(input int lg, input bit noisy);
    for (int i = 0; i < (1 << lg); i++) begin
      if (noisy && $urandom_range(19) == 0) send_pull();
      send_req(FUNC_PUSH, pick_sample(), pick_sample());
    end
    if (noisy && $urandom_range(3) == 0) send_req(FUNC_PUSH, pick_sample(), pick_sample());
    for (int i = 0; i < (1 << lg); i++) send_pull();
    if (noisy && $urandom_range(3) == 0) send_pull();
  endtask

  initial begin
    int frame_no;
    int lg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    req_count = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: pull with nothing loaded, smallest frames, extremes
    set_mode(1'b0, 1'b0, 1);
    send_req(FUNC_PULL, 16'sh7fff, 16'sh8000);
    send_req(FUNC_PUSH, 16'sh7fff, 16'sh8000);
    send_req(FUNC_PUSH, 16'sh8000, 16'sh7fff);
    send_req(FUNC_PULL, '0, '0);
    send_req(FUNC_PULL, '0, '0);
    // two-point frame with DC centred, inverse
    set_mode(1'b1, 1'b1, 1);
    send_req(FUNC_PUSH, 16'sh8000, 16'sh8000);
    send_req(FUNC_PUSH, 16'sh7fff, 16'sh7fff);
    // push while a frame waits is dropped
    send_req(FUNC_PUSH, 16'sh1234, 16'sh4321);
    send_req(FUNC_PULL, '0, '0);
    send_req(FUNC_PULL, '0, '0);
    // length shrunk part way through loading
    set_mode(1'b0, 1'b1, 3);
    repeat (5) send_req(FUNC_PUSH, pick_sample(), pick_sample());
    drain();
    write_reg(REG_LOG2_LEN, CFG_BITS'(2));
    send_req(FUNC_PUSH, 16'sh7fff, 16'sh0001);
    repeat (4) send_req(FUNC_PULL, '0, '0);
    // unknown register, out-of-range lengths saturate
    set_mode(1'b1, 1'b0, 0);
    write_reg(REG_LOG2_LEN + 2'd1, 4'hf);
    run_frame(1, 1'b0);
    set_mode(1'b0, 1'b0, 15);
    write_reg(REG_LOG2_LEN, CFG_BITS'(4));
    run_frame(4, 1'b0);

    // random frames; one long frame with no idling
    frame_no = 0;
    while (req_count < 400 || frame_no < 2) begin
      calm = (frame_no == 1);
      lg = (frame_no == 1) ? 7 : int'($urandom_range(1, 5));
      set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), lg);
      run_frame(lg, 1'b1);
      frame_no++;
    end
    calm = 1'b0;

    drain();
    if (fail_count == 0) begin
      $display("[radix2_complex_fft] OK");
    end else begin
      $display("[radix2_complex_fft] ERROR");
    end
    $finish;
  end

endmodule
